[src/ddo_pkg.sv]
// Shared types, constants and the arctangent table for the odometry block.
package ddo_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int ITER_BITS    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int CHUNK_BITS   = 17;

   localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032874;

   localparam logic [1:0] CSR_LEFT_SCALE  = 2'd0;
   localparam logic [1:0] CSR_RIGHT_SCALE = 2'd1;
   localparam logic [1:0] CSR_TURN_GAIN   = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DRAIN,
      S_TAKE,
      S_CORDIC,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_LEFT,
      OP_RIGHT,
      OP_TURN,
      OP_COS,
      OP_SIN
   } mop_type;

   // One multiply-accumulate request: a times b, shifted left by chunk * CHUNK_BITS.
   typedef struct packed {
      logic               issue;
      logic               clear;
      logic signed [34:0] a;
      logic signed [17:0] b;
      logic [1:0]         chunk;
   } mac_req_type;

   // atan(2^-i) as a binary angle, 2^32 per turn.
   function automatic logic [31:0] atan_angle(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         5'd24:   v = 32'h00000029;
         5'd25:   v = 32'h00000014;
         5'd26:   v = 32'h0000000A;
         5'd27:   v = 32'h00000005;
         5'd28:   v = 32'h00000003;
         5'd29:   v = 32'h00000001;
         5'd30:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

[src/differential_drive_odometry.sv]
// Differential-drive wheel odometry: a sequencer around a shared multiplier and a CORDIC.
// The serial CORDIC rotations and nine passes through the one 35x18 multiply-accumulate unit
// are done for one item before the next is taken; req_tready is low meanwhile.
// The first item after reset only loads the previous counts and gives no result.
// Reset is synchronous, active high; it restores the register defaults and clears the pose.
module differential_drive_odometry (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // left_count [15:0], right_count [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // x_position [31:0], y_position [63:32], heading_angle [95:64]
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [39:0] csr_wdata
);
   import ddo_pkg::*;

   state_type          state_ff, state_in;
   mop_type            mop_ff, mop_in;
   logic [1:0]         chunk_ff, chunk_in;
   logic [1:0]         last_chunk;

   logic [23:0]        left_scale_ff, left_scale_in;
   logic [23:0]        right_scale_ff, right_scale_in;
   logic [39:0]        turn_gain_ff, turn_gain_in;

   logic [15:0]        prev_left_ff, prev_left_in;
   logic [15:0]        prev_right_ff, prev_right_in;
   logic               first_ff, first_in;
   logic signed [17:0] neg_dl_ff, neg_dl_in;
   logic signed [17:0] dr_ff, dr_in;
   logic signed [31:0] left_ff, left_in;
   logic signed [32:0] diff_ff, diff_in;
   logic signed [31:0] travel_ff, travel_in;
   logic [31:0]        heading_ff, heading_in;
   logic [31:0]        pos_x_ff, pos_x_in;
   logic [31:0]        pos_y_ff, pos_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   logic               req_acc;
   logic               out_free;
   logic [15:0]        left_count, right_count;
   logic [15:0]        dl_raw, dr_raw;
   logic signed [32:0] right_ext, left_ext, wheel_sum;
   logic [31:0]        heading_next;

   mac_req_type        mreq;
   logic signed [63:0] acc;
   logic               cor_start;
   logic               cor_done;
   logic signed [31:0] cos_val, sin_val;
   logic signed [31:0] trig_val;

   ddo_mac u_mac (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .acc   (acc)
   );

   ddo_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (heading_next),
      .done    (cor_done),
      .cos_val (cos_val),
      .sin_val (sin_val)
   );

   assign left_count  = req_tdata[15:0];
   assign right_count = req_tdata[31:16];
   assign req_acc     = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign dl_raw      = left_count - prev_left_ff;
   assign dr_raw      = right_count - prev_right_ff;

   assign right_ext    = {acc[39], acc[39:8]};
   assign left_ext     = {left_ff[31], left_ff};
   assign wheel_sum    = left_ext + right_ext;
   assign heading_next = heading_ff - acc[47:16];
   assign trig_val     = (mop_ff == OP_SIN) ? sin_val : cos_val;

   always_comb begin
      unique case (mop_ff) inside
         OP_TURN:        last_chunk = 2'd2;
         OP_COS, OP_SIN: last_chunk = 2'd1;
         default:        last_chunk = 2'd0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && !first_ff) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (chunk_ff == last_chunk) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_TAKE;
         S_TAKE: begin
            if (mop_ff == OP_TURN) begin
               state_in = S_CORDIC;
            end else if (mop_ff == OP_SIN) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_CORDIC: begin
            if (cor_done) begin
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, multiplier request and CORDIC start.
   always_comb begin
      req_tready = 1'b0;
      cor_start  = 1'b0;
      mreq.issue = 1'b0;
      mreq.clear = (chunk_ff == 2'd0);
      mreq.chunk = chunk_ff;
      mreq.a     = '0;
      mreq.b     = '0;
      unique case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_MUL:   mreq.issue = 1'b1;
         S_TAKE:  cor_start  = (mop_ff == OP_TURN);
         default: ;
      endcase
      unique case (mop_ff)
         OP_LEFT: begin
            mreq.a = {11'b0, left_scale_ff};
            mreq.b = neg_dl_ff;
         end
         OP_RIGHT: begin
            mreq.a = {11'b0, right_scale_ff};
            mreq.b = dr_ff;
         end
         OP_TURN: begin
            mreq.a = {{2{diff_ff[32]}}, diff_ff};
            case (chunk_ff)
               2'd0:    mreq.b = {1'b0, turn_gain_ff[16:0]};
               2'd1:    mreq.b = {1'b0, turn_gain_ff[33:17]};
               default: mreq.b = {12'b0, turn_gain_ff[39:34]};
            endcase
         end
         default: begin
            mreq.a = {{3{travel_ff[31]}}, travel_ff};
            if (chunk_ff == 2'd0) begin
               mreq.b = {1'b0, trig_val[16:0]};
            end else begin
               mreq.b = {{3{trig_val[31]}}, trig_val[31:17]};
            end
         end
      endcase
   end

   // Datapath and state updates.
   always_comb begin
      mop_in         = mop_ff;
      chunk_in       = 2'd0;
      left_scale_in  = left_scale_ff;
      right_scale_in = right_scale_ff;
      turn_gain_in   = turn_gain_ff;
      prev_left_in   = prev_left_ff;
      prev_right_in  = prev_right_ff;
      first_in       = first_ff;
      neg_dl_in      = neg_dl_ff;
      dr_in          = dr_ff;
      left_in        = left_ff;
      diff_in        = diff_ff;
      travel_in      = travel_ff;
      heading_in     = heading_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      if (csr_wen) begin
         unique case (csr_index)
            CSR_LEFT_SCALE:  left_scale_in  = csr_wdata[23:0];
            CSR_RIGHT_SCALE: right_scale_in = csr_wdata[23:0];
            CSR_TURN_GAIN:   turn_gain_in   = csr_wdata;
            default: ;
         endcase
      end

      if (state_ff == S_MUL && chunk_ff != last_chunk) begin
         chunk_in = chunk_ff + 2'd1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               prev_left_in  = left_count;
               prev_right_in = right_count;
               first_in      = 1'b0;
               // The left wheel counts the other way, so its change is negated.
               neg_dl_in     = 18'sd0 - {{2{dl_raw[15]}}, dl_raw};
               dr_in         = {{2{dr_raw[15]}}, dr_raw};
               mop_in        = OP_LEFT;
            end
         end
         S_TAKE: begin
            unique case (mop_ff)
               OP_LEFT: begin
                  left_in = acc[39:8];
                  mop_in  = OP_RIGHT;
               end
               OP_RIGHT: begin
                  travel_in = wheel_sum[32:1];
                  diff_in   = right_ext - left_ext;
                  mop_in    = OP_TURN;
               end
               OP_TURN: begin
                  heading_in = heading_next;
               end
               OP_COS: begin
                  pos_x_in = pos_x_ff + acc[61:30];
                  mop_in   = OP_SIN;
               end
               default: begin
                  pos_y_in = pos_y_ff + acc[61:30];
               end
            endcase
         end
         S_CORDIC: begin
            if (cor_done) begin
               mop_in = OP_COS;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {heading_ff, pos_y_ff, pos_x_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mop_ff         <= OP_LEFT;
         chunk_ff       <= 2'd0;
         left_scale_ff  <= 24'd97308;
         right_scale_ff <= 24'd97308;
         turn_gain_ff   <= 40'd3417826400;
         prev_left_ff   <= 16'd0;
         prev_right_ff  <= 16'd0;
         first_ff       <= 1'b1;
         heading_ff     <= 32'd0;
         pos_x_ff       <= 32'd0;
         pos_y_ff       <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mop_ff         <= mop_in;
         chunk_ff       <= chunk_in;
         left_scale_ff  <= left_scale_in;
         right_scale_ff <= right_scale_in;
         turn_gain_ff   <= turn_gain_in;
         prev_left_ff   <= prev_left_in;
         prev_right_ff  <= prev_right_in;
         first_ff       <= first_in;
         heading_ff     <= heading_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      neg_dl_ff   <= neg_dl_in;
      dr_ff       <= dr_in;
      left_ff     <= left_in;
      diff_ff     <= diff_in;
      travel_ff   <= travel_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[src/ddo_mac.sv]
// Shared signed multiply-accumulate unit: one registered product, then a shifted accumulate.
module ddo_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  ddo_pkg::mac_req_type mreq,
   output logic signed [63:0]   acc
);
   import ddo_pkg::*;

   logic               valid_ff, valid_in;
   logic               clear_ff;
   logic [1:0]         chunk_ff;
   logic signed [52:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ext;
   logic signed [63:0] addend;

   assign prod_in  = mreq.a * mreq.b;
   assign valid_in = mreq.issue;
   assign prod_ext = {{11{prod_ff[52]}}, prod_ff};

   always_comb begin
      case (chunk_ff)
         2'd0:    addend = prod_ext;
         2'd1:    addend = prod_ext <<< CHUNK_BITS;
         2'd2:    addend = prod_ext <<< (2 * CHUNK_BITS);
         default: addend = prod_ext <<< (3 * CHUNK_BITS);
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (valid_ff) begin
         acc_in = (clear_ff ? 64'sd0 : acc_ff) + addend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prod_ff  <= prod_in;
      clear_ff <= mreq.clear;
      chunk_ff <= mreq.chunk;
      acc_ff   <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[src/ddo_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cosine and sine in Q2.30.
module ddo_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        angle,
   output logic               done,
   output logic signed [31:0] cos_val,
   output logic signed [31:0] sin_val
);
   import ddo_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic                 flip_ff, flip_in;
   logic signed [31:0]   x_ff, x_in;
   logic signed [31:0]   y_ff, y_in;
   logic signed [32:0]   z_ff, z_in;
   logic signed [31:0]   cos_ff, cos_in;
   logic signed [31:0]   sin_ff, sin_in;
   logic signed [31:0]   dx, dy;
   logic signed [32:0]   step_angle;
   logic                 flip_start;

   assign dx         = y_ff >>> iter_ff;
   assign dy         = x_ff >>> iter_ff;
   assign step_angle = {1'b0, atan_angle(5'(iter_ff))};
   // Angles in the second and third quadrant are turned by a half turn first.
   assign flip_start = angle[31] ^ angle[30];

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      iter_in = iter_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         flip_in = flip_start;
         x_in    = CORDIC_K_Q30;
         y_in    = 32'sd0;
         z_in    = {angle[30], angle[30], angle[30:0]};
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step_angle;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step_angle;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_BITS'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         cos_in  = flip_ff ? -x_ff : x_ff;
         sin_in  = flip_ff ? -y_ff : y_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done    = done_ff;
   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

endmodule

[test/pose_tracker.sv]
// Pose tracker for the odometry block: predicts every pose and compares it with the output.
module pose_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // left_count [15:0], right_count [31:16]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,   // x_position [31:0], y_position [63:32], heading_angle [95:64]
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [39:0] csr_wdata,
   output int          outstanding,
   output int          poses_checked,
   output int          error_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ddo_pkg::*;

   // Packed so that the x position sits in the low bits, as on rsp_tdata.
   typedef struct packed {
      logic [31:0]        heading;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } pose_type;

   // Rotation angle of each CORDIC iteration, atan(2^-i), 2^32 per turn.
   longint arc_table [0:31] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
      64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
   };

   logic [23:0] left_tick_len;
   logic [23:0] right_tick_len;
   logic [39:0] turn_rate;
   logic [15:0] last_left;
   logic [15:0] last_right;
   logic        primed;
   pose_type    pose_now;
   pose_type    pose_queue [$];
   pose_type    want;
   pose_type    got;
   int          mismatches = 0;
   int          checked = 0;

   // Cosine and sine of the heading in Q2.30.
   function automatic void resolve_heading(input logic [31:0] angle, output longint cos_q30,
                                           output longint sin_q30);
      logic        flip;
      logic [31:0] folded;
      longint      cx;
      longint      sy;
      longint      z;
      longint      dx;
      longint      dy;
      int          i;
      // The back half turn is rotated by half a turn and the result negated afterwards.
      flip   = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
      folded = flip ? angle + 32'h8000_0000 : angle;
      z      = longint'($signed(folded));
      cx     = longint'(CORDIC_K_Q30);
      sy     = 0;
      for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         dx = sy >>> i;
         dy = cx >>> i;
         if (z >= 0) begin
            cx = cx - dx;
            sy = sy + dy;
            z  = z - arc_table[i];
         end else begin
            cx = cx + dx;
            sy = sy - dy;
            z  = z + arc_table[i];
         end
      end
      cos_q30 = flip ? -cx : cx;
      sin_q30 = flip ? -sy : sy;
   endfunction

   // Advances the odometry by one encoder sample; returns 1 when the sample yields a pose.
   function automatic logic take_sample(input logic [15:0] lc, input logic [15:0] rc,
                                        output pose_type pose);
      logic signed [15:0] dl;
      logic signed [15:0] dr;
      longint             left_m;
      longint             right_m;
      longint             travel;
      longint             cos_q30;
      longint             sin_q30;
      longint             shift_x;
      longint             shift_y;
      logic [63:0]        spread;
      logic [63:0]        turn;
      pose = pose_now;
      if (!primed) begin
         last_left  = lc;
         last_right = rc;
         primed     = 1'b1;
         return 1'b0;
      end
      dl         = lc - last_left;
      dr         = rc - last_right;
      last_left  = lc;
      last_right = rc;
      // The left encoder counts down when that wheel rolls forward.
      left_m  = (-longint'(dl) * longint'(left_tick_len)) >>> 8;
      right_m = (longint'(dr) * longint'(right_tick_len)) >>> 8;
      travel  = (left_m + right_m) >>> 1;
      // Only bits 16 to 47 of the turn product reach the heading, so a wrapped product is fine.
      spread  = right_m - left_m;
      turn    = spread * {24'd0, turn_rate};
      pose_now.heading = pose_now.heading - turn[47:16];
      resolve_heading(pose_now.heading, cos_q30, sin_q30);
      shift_x    = (travel * cos_q30) >>> 30;
      shift_y    = (travel * sin_q30) >>> 30;
      pose_now.x = pose_now.x + shift_x[31:0];
      pose_now.y = pose_now.y + shift_y[31:0];
      pose       = pose_now;
      return 1'b1;
   endfunction

   task automatic compare_field(input string label, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s expected %h, got %h", $time, label, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         left_tick_len  = 24'd97308;
         right_tick_len = 24'd97308;
         turn_rate      = 40'd3417826400;
         last_left      = '0;
         last_right     = '0;
         primed         = 1'b0;
         pose_now       = '0;
         pose_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pose_queue.size() == 0) begin
               $display("%0t: pose %h arrived with none predicted", $time, got);
               mismatches++;
            end else begin
               want = pose_queue.pop_front();
               compare_field("x_position", want.x, got.x);
               compare_field("y_position", want.y, got.y);
               compare_field("heading_angle", want.heading, got.heading);
               checked++;
            end
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_LEFT_SCALE:  left_tick_len  = csr_wdata[23:0];
               CSR_RIGHT_SCALE: right_tick_len = csr_wdata[23:0];
               CSR_TURN_GAIN:   turn_rate      = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (take_sample(req_tdata[15:0], req_tdata[31:16], want))
               pose_queue.push_back(want);
         end
      end
      outstanding   <= pose_queue.size();
      poses_checked <= checked;
      error_count   <= mismatches;
   end

endmodule

[test/testbench.sv]
// Top of the odometry test: clock, reset, register settings, encoder samples and the verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ddo_pkg::*;

   // Index past the register list; the block has to ignore writes to it.
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES     = 64;
   localparam int PHASES            = 8;
   localparam int PHASE_ITEMS       = 236;
   // About ten times the slowest expected run with every stall pattern.
   localparam int LIMIT_CYCLES      = 1_000_000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // left_count [15:0], right_count [31:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;         // x_position [31:0], y_position [63:32], heading_angle [95:64]
   logic        csr_wen    = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [39:0] csr_wdata  = '0;

   int          outstanding;
   int          poses_checked;
   int          error_count;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   int          phase;
   logic [15:0] left_now;
   logic [15:0] right_now;

   // Opening samples, {right, left}: priming, standstill, straight run, pivot, spin,
   // a half-range jump that reads as -32768, the largest positive change, and counter wraps.
   logic [31:0] opening_moves [0:15] = '{
      32'h5678_1234, 32'h5678_1234, 32'h56DC_11D0, 32'h5740_11D0,
      32'h57A4_1234, 32'hD7A4_1234, 32'hD7A4_9233, 32'hFFFF_FFFF,
      32'h0000_0000, 32'h0001_FFFF, 32'h8000_8000, 32'hFFFF_0000,
      32'h8000_7FFF, 32'h7FFF_8000, 32'h0000_FFFF, 32'hFFFF_0000
   };
   logic [15:0] count_corners [0:3] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};

   differential_drive_odometry DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pose_tracker tracker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .outstanding   (outstanding),
      .poses_checked (poses_checked),
      .error_count   (error_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Valid stays high from one item to the next unless a gap is drawn.
   task automatic send_item(input logic [15:0] lc, input logic [15:0] rc);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rc, lc};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_random();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         // Ordinary driving: small changes of both counts.
         left_now  = left_now + 16'($urandom_range(600)) - 16'd300;
         right_now = right_now + 16'($urandom_range(600)) - 16'd300;
      end else if (pick < 85) begin
         left_now  = left_now + 16'($urandom);
         right_now = right_now + 16'($urandom);
      end else if (pick < 95) begin
         {right_now, left_now} = $urandom;
      end else begin
         left_now  = count_corners[$urandom_range(3)];
         right_now = count_corners[$urandom_range(3)];
      end
      send_item(left_now, right_now);
   endtask

   // Drops valid and waits until every predicted pose is back and the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input int k);
      logic [39:0] lval;
      logic [39:0] rval;
      logic [39:0] gval;
      case (k) inside
         0, 7: begin
            lval = 40'd97308;
            rval = 40'd97308;
            gval = 40'd3417826400;
         end
         1: begin
            lval = 40'hFF_FFFF;
            rval = 40'hFF_FFFF;
            gval = 40'hFF_FFFF_FFFF;
         end
         2: begin
            lval = '0;
            rval = '0;
            gval = '0;
         end
         4: begin
            lval = 40'hFF_FFFF;
            rval = '0;
            gval = 40'($urandom);
         end
         5: begin
            lval = 40'($urandom_range(150000, 50000));
            rval = 40'($urandom_range(150000, 50000));
            gval = 40'($urandom);
         end
         6: begin
            // Bits above the scale width must be dropped by the block.
            lval = {16'($urandom_range(65535, 1)), 24'($urandom)};
            rval = {16'($urandom_range(65535, 1)), 24'($urandom)};
            gval = 40'({$urandom, $urandom});
         end
         default: begin
            lval = 40'($urandom);
            rval = 40'($urandom);
            gval = 40'({$urandom, $urandom});
         end
      endcase
      csr_wen   <= 1'b1;
      csr_index <= CSR_LEFT_SCALE;
      csr_wdata <= lval;
      @(posedge clock);
      csr_index <= CSR_RIGHT_SCALE;
      csr_wdata <= rval;
      @(posedge clock);
      csr_index <= CSR_TURN_GAIN;
      csr_wdata <= gval;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= 40'({$urandom, $urandom});
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_moves[i])
         send_item(opening_moves[i][15:0], opening_moves[i][31:16]);
      left_now  = 16'h0000;
      right_now = 16'hFFFF;
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         apply_setting(phase);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 76; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
         endcase
         repeat (PHASE_ITEMS) send_random();
      end
      settle();
      $display("Drove %0d encoder samples through %0d register settings and four flow patterns;",
               items_sent, PHASES + 1);
      $display("%0d poses were compared field by field, %0d field errors.",
               poses_checked, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[differential_drive_odometry.f]
src/ddo_pkg.sv
src/ddo_mac.sv
src/ddo_cordic.sv
src/differential_drive_odometry.sv
test/pose_tracker.sv
test/testbench.sv
